@@ rtl/ccds_pkg.sv @@
package ccds_pkg;

  // one input word
  typedef struct packed {
    logic [1:0]  cmd;
    logic [18:0] add_amount;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [6:0]  set_low;
    logic        blank;
    logic [1:0]  blank_field;
  } ccds_in_t;

  // one result word
  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [6:0] low_now;
    logic [7:0] segment_pattern;
    logic [7:0] digit_select;
  } ccds_out_t;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_SCAN = 2'd2
  } ccds_cmd_e;

  // field chosen for blanking
  localparam logic [1:0] BLANK_LOW    = 2'd1;
  localparam logic [1:0] BLANK_MINUTE = 2'd2;
  localparam logic [1:0] BLANK_HOUR   = 2'd3;

  // display positions that show a digit; the rest show a dash
  localparam logic [2:0] POS_LOW_ONES  = 3'd0;
  localparam logic [2:0] POS_LOW_TENS  = 3'd1;
  localparam logic [2:0] POS_MIN_ONES  = 3'd3;
  localparam logic [2:0] POS_MIN_TENS  = 3'd4;
  localparam logic [2:0] POS_HOUR_ONES = 3'd6;
  localparam logic [2:0] POS_HOUR_TENS = 3'd7;

  // field bases
  localparam logic [6:0] BASE_SEC   = 7'd60;
  localparam logic [6:0] BASE_HUND  = 7'd100;
  localparam logic [7:0] BASE2_SEC  = 8'd120;
  localparam logic [7:0] BASE2_HUND = 8'd200;

  // exact reciprocals for dividing a 19-bit amount: shift = 19 + ceil(log2(divisor))
  localparam int unsigned SH_60     = 25;
  localparam int unsigned SH_100    = 26;
  localparam int unsigned SH_3600   = 31;
  localparam int unsigned SH_6000   = 32;
  localparam int unsigned SH_86400  = 36;
  localparam int unsigned SH_144000 = 37;

  localparam logic [19:0] RCP_60     = 20'(((64'd1 << SH_60) + 64'd59) / 64'd60);
  localparam logic [19:0] RCP_100    = 20'(((64'd1 << SH_100) + 64'd99) / 64'd100);
  localparam logic [19:0] RCP_3600   = 20'(((64'd1 << SH_3600) + 64'd3599) / 64'd3600);
  localparam logic [19:0] RCP_6000   = 20'(((64'd1 << SH_6000) + 64'd5999) / 64'd6000);
  localparam logic [19:0] RCP_86400  = 20'(((64'd1 << SH_86400) + 64'd86399) / 64'd86400);
  localparam logic [19:0] RCP_144000 =
    20'(((64'd1 << SH_144000) + 64'd143999) / 64'd144000);

  localparam logic [7:0] SEG_DASH  = 8'h40;
  localparam logic [7:0] SEG_BLANK = 8'h00;

  // decimal digit to segment byte
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/clock_counter_with_digit_scan.sv @@
// clock / stopwatch counter with eight-digit seven-segment scan
//
// in channel (in_valid_i / in_ready_o / in_data_i) takes one command word:
// add an amount to the low field, set all counts, or scan one display digit.
// out channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result word per command: the counts after the command and, for a scan,
// the segment byte and one-hot digit select (both zero otherwise).
// cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i), always ready, writes the
// stopwatch mode bit; the user must write it only while the block is idle (not enforced).
//
// a word accepted into the input register passes the divide stage, the residue
// stage and the update stage, then shows up on the out channel from the result reg.
// throughput: one word per cycle when out_ready_i does not stall; the update stage
// reads and writes the counts in the same cycle, so back-to-back words always see fresh counts.
// reset clears the counts, scan position, mode and all valid flags.
// a stall on out_ready_i holds the result register; the stages behind it
// keep filling until each holds a word, then in_ready_o drops.
module clock_counter_with_digit_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccds_pkg::ccds_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccds_pkg::ccds_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import ccds_pkg::*;

  // quotients of the raw amount, carried with the word
  typedef struct packed {
    ccds_in_t   word;
    logic [13:0] q_low;   // amount / base
    logic [7:0]  q_min;   // amount / (base * 60)
    logic [2:0]  q_hour;  // amount / (base * 1440)
  } ccds_div_t;

  // residues and reduced set values ready for the update stage
  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] r_low;
    logic [5:0] r_min;
    logic [4:0] r_hour;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [6:0] set_low;
    logic       blank;
    logic [1:0] blank_field;
  } ccds_res_t;

  // control state
  logic       mode_q;
  logic       a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [6:0] low_q, low_d;
  logic [2:0] pos_q, pos_d;

  // payload
  ccds_in_t  a_q;
  ccds_div_t b_q, b_d;
  ccds_res_t c_q, c_d;
  ccds_out_t out_q, out_d;

  logic out_free, c_free, b_free, a_free, c_fire;

  // stall chain: a stage may load when it is empty or its word moves on
  assign out_free   = !out_valid_q || out_ready_i;
  assign c_fire     = c_valid_q && out_free;
  assign c_free     = !c_valid_q || out_free;
  assign b_free     = !b_valid_q || c_free;
  assign a_free     = !a_valid_q || b_free;
  assign in_ready_o = a_free;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // divide stage: three independent reciprocal multiplies
  // ---------------------------------------------------------------------
  logic [38:0] prod_low, prod_min, prod_hour;

  always_comb begin
    prod_low  = 39'(a_q.add_amount) * 39'(mode_q ? RCP_100 : RCP_60);
    prod_min  = 39'(a_q.add_amount) * 39'(mode_q ? RCP_6000 : RCP_3600);
    prod_hour = 39'(a_q.add_amount) * 39'(mode_q ? RCP_144000 : RCP_86400);
    b_d.word   = a_q;
    b_d.q_low  = mode_q ? 14'(prod_low >> SH_100) : 14'(prod_low >> SH_60);
    b_d.q_min  = mode_q ? 8'(prod_min >> SH_6000) : 8'(prod_min >> SH_3600);
    b_d.q_hour = mode_q ? 3'(prod_hour >> SH_144000) : 3'(prod_hour >> SH_86400);
  end

  // ---------------------------------------------------------------------
  // residue stage: reduce the set values and peel each quotient into the digit of its own field
  // ---------------------------------------------------------------------
  logic [6:0]  base;
  logic [7:0]  base2;
  logic [19:0] r_low_w;
  logic [13:0] r_min_w;
  logic [7:0]  r_hour_w;
  logic [7:0]  set_low_w;

  assign base  = mode_q ? BASE_HUND : BASE_SEC;
  assign base2 = mode_q ? BASE2_HUND : BASE2_SEC;

  always_comb begin
    r_low_w  = 20'(b_q.word.add_amount) - 20'(b_q.q_low) * 20'(base);
    r_min_w  = b_q.q_low - 14'(b_q.q_min) * 14'd60;
    r_hour_w = b_q.q_min - 8'(b_q.q_hour) * 8'd24;
    set_low_w = 8'(b_q.word.set_low);
    if (set_low_w >= base2) begin
      set_low_w = set_low_w - base2;
    end else if (set_low_w >= 8'(base)) begin
      set_low_w = set_low_w - 8'(base);
    end
    c_d.cmd         = b_q.word.cmd;
    c_d.r_low       = r_low_w[6:0];
    c_d.r_min       = r_min_w[5:0];
    c_d.r_hour      = r_hour_w[4:0];
    c_d.set_hour    = (b_q.word.set_hour >= 5'd24) ? b_q.word.set_hour - 5'd24
                                                   : b_q.word.set_hour;
    c_d.set_minute  = (b_q.word.set_minute >= 6'd60) ? b_q.word.set_minute - 6'd60
                                                     : b_q.word.set_minute;
    c_d.set_low     = set_low_w[6:0];
    c_d.blank       = b_q.word.blank;
    c_d.blank_field = b_q.word.blank_field;
  end

  // ---------------------------------------------------------------------
  // update stage: add residues to the counts with small carries
  // ---------------------------------------------------------------------
  logic [7:0] sum_low, add_low;
  logic [1:0] carry_low, carry_min;
  logic [6:0] sum_min, add_min;
  logic [5:0] sum_hour, add_hour;

  always_comb begin
    // low + residue stays below twice the base... or three times for a
    // stale stopwatch count seen in clock mode
    sum_low = 8'(low_q) + 8'(c_q.r_low);
    if (sum_low >= base2) begin
      add_low   = sum_low - base2;
      carry_low = 2'd2;
    end else if (sum_low >= 8'(base)) begin
      add_low   = sum_low - 8'(base);
      carry_low = 2'd1;
    end else begin
      add_low   = sum_low;
      carry_low = 2'd0;
    end
    sum_min = 7'(minutes_q) + 7'(c_q.r_min) + 7'(carry_low);
    if (sum_min >= 7'd120) begin
      add_min   = sum_min - 7'd120;
      carry_min = 2'd2;
    end else if (sum_min >= 7'd60) begin
      add_min   = sum_min - 7'd60;
      carry_min = 2'd1;
    end else begin
      add_min   = sum_min;
      carry_min = 2'd0;
    end
    sum_hour = 6'(hours_q) + 6'(c_q.r_hour) + 6'(carry_min);
    if (sum_hour >= 6'd48) begin
      add_hour = sum_hour - 6'd48;
    end else if (sum_hour >= 6'd24) begin
      add_hour = sum_hour - 6'd24;
    end else begin
      add_hour = sum_hour;
    end
  end

  // digit for the current scan position
  logic [6:0]  field_val;
  logic        use_tens, blanked, is_dash;
  logic [14:0] tens_prod;
  logic [3:0]  tens, ones;
  logic [6:0]  ones_w;
  logic [7:0]  scan_seg;

  always_comb begin
    field_val = '0;
    use_tens  = 1'b0;
    blanked   = 1'b0;
    is_dash   = 1'b0;
    case (pos_q)
      POS_LOW_ONES, POS_LOW_TENS: begin
        field_val = low_q;
        use_tens  = (pos_q == POS_LOW_TENS);
        blanked   = c_q.blank && (c_q.blank_field == BLANK_LOW);
      end
      POS_MIN_ONES, POS_MIN_TENS: begin
        field_val = 7'(minutes_q);
        use_tens  = (pos_q == POS_MIN_TENS);
        blanked   = c_q.blank && (c_q.blank_field == BLANK_MINUTE);
      end
      POS_HOUR_ONES, POS_HOUR_TENS: begin
        field_val = 7'(hours_q);
        use_tens  = (pos_q == POS_HOUR_TENS);
        blanked   = c_q.blank && (c_q.blank_field == BLANK_HOUR);
      end
      default: begin
        is_dash = 1'b1;
      end
    endcase
    // divide by ten: exact for values up to 99
    tens_prod = 15'(field_val) * 15'd205;
    tens      = 4'(tens_prod >> 11);
    ones_w    = field_val - 7'(tens) * 7'd10;
    ones      = ones_w[3:0];
    if (is_dash) begin
      scan_seg = SEG_DASH;
    end else if (blanked) begin
      scan_seg = SEG_BLANK;
    end else begin
      scan_seg = seg_code(use_tens ? tens : ones);
    end
  end

  // command decode
  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    low_d     = low_q;
    pos_d     = pos_q;
    out_d.segment_pattern = 8'h00;
    out_d.digit_select    = 8'h00;
    unique case (c_q.cmd)
      CMD_ADD: begin
        hours_d   = add_hour[4:0];
        minutes_d = add_min[5:0];
        low_d     = add_low[6:0];
      end
      CMD_SET: begin
        hours_d   = c_q.set_hour;
        minutes_d = c_q.set_minute;
        low_d     = c_q.set_low;
      end
      CMD_SCAN: begin
        out_d.segment_pattern = scan_seg;
        out_d.digit_select    = 8'h80 >> pos_q;
        pos_d                 = pos_q + 3'd1;
      end
      default: begin
      end
    endcase
    out_d.hour_now   = hours_d;
    out_d.minute_now = minutes_d;
    out_d.low_now    = low_d;
  end

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hours_q     <= '0;
      minutes_q   <= '0;
      low_q       <= '0;
      pos_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (a_free) begin
        a_valid_q <= in_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
      if (c_free) begin
        c_valid_q <= b_valid_q;
      end
      if (out_free) begin
        out_valid_q <= c_valid_q;
      end
      if (c_fire) begin
        hours_q   <= hours_d;
        minutes_q <= minutes_d;
        low_q     <= low_d;
        pos_q     <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_free) begin
      a_q <= in_data_i;
    end
    if (a_valid_q && b_free) begin
      b_q <= b_d;
    end
    if (b_valid_q && c_free) begin
      c_q <= c_d;
    end
    if (c_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // counts leaving the block are always in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hour_now < 5'd24) && (out_data_o.minute_now < 6'd60)
                    && (out_data_o.low_now < 7'd100))
    else $error("count out of range on result word");

  // at most one digit enabled, and no segments without a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(out_data_o.digit_select)
                    && ((out_data_o.digit_select != 8'h00)
                        || (out_data_o.segment_pattern == 8'h00)))
    else $error("segment byte without a single digit select");

  // counts and scan position change only when the update stage fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_fire |=> $stable(hours_q) && $stable(minutes_q) && $stable(low_q)
                && $stable(pos_q))
    else $error("state changed without an executed word");

endmodule

@@ sim/clock_counter_checker.sv @@
`timescale 1ns / 1ps

// watches the in, out and cfg channels of the clock counter, keeps its own
// copy of the counts and scan position, and compares every result word
module clock_counter_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ccds_pkg::ccds_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ccds_pkg::ccds_out_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         open_count_o
);
  import ccds_pkg::*;

  // segment bytes for 9 down to 0
  localparam logic [9:0][7:0] DIGIT_SEGS = {
    8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  logic [4:0] hours_q    = '0;
  logic [5:0] minutes_q  = '0;
  logic [6:0] low_q      = '0;
  logic [2:0] scan_pos_q = '0;
  logic       stopwatch_q = 1'b0;

  ccds_out_t readout_q[$];

  function automatic logic [7:0] digit_segs(input int unsigned value, input bit tens,
                                            input bit blanked);
    int unsigned d;
    d = tens ? value / 10 : value % 10;
    return blanked ? SEG_BLANK : DIGIT_SEGS[d % 10];
  endfunction

  // applies one command word to the counts and returns the readout it gives
  function automatic ccds_out_t next_readout(input ccds_in_t w);
    ccds_out_t   r;
    int unsigned base;
    int unsigned low_sum;
    int unsigned min_sum;
    bit          bl;
    r    = '0;
    base = stopwatch_q ? 100 : 60;
    bl   = w.blank;
    case (w.cmd)
      CMD_ADD: begin
        low_sum   = low_q + w.add_amount;
        min_sum   = minutes_q + low_sum / base;
        low_q     = low_sum % base;
        hours_q   = (hours_q + min_sum / 60) % 24;
        minutes_q = min_sum % 60;
      end
      CMD_SET: begin
        hours_q   = w.set_hour % 24;
        minutes_q = w.set_minute % 60;
        low_q     = w.set_low % base;
      end
      CMD_SCAN: begin
        case (scan_pos_q)
          POS_LOW_ONES:  r.segment_pattern = digit_segs(low_q, 1'b0,
                                                        bl && w.blank_field == BLANK_LOW);
          POS_LOW_TENS:  r.segment_pattern = digit_segs(low_q, 1'b1,
                                                        bl && w.blank_field == BLANK_LOW);
          POS_MIN_ONES:  r.segment_pattern = digit_segs(minutes_q, 1'b0,
                                                        bl && w.blank_field == BLANK_MINUTE);
          POS_MIN_TENS:  r.segment_pattern = digit_segs(minutes_q, 1'b1,
                                                        bl && w.blank_field == BLANK_MINUTE);
          POS_HOUR_ONES: r.segment_pattern = digit_segs(hours_q, 1'b0,
                                                        bl && w.blank_field == BLANK_HOUR);
          POS_HOUR_TENS: r.segment_pattern = digit_segs(hours_q, 1'b1,
                                                        bl && w.blank_field == BLANK_HOUR);
          default:       r.segment_pattern = SEG_DASH;
        endcase
        r.digit_select = 8'h80 >> scan_pos_q;
        scan_pos_q     = scan_pos_q + 3'd1;
      end
      default: ;
    endcase
    r.hour_now   = hours_q;
    r.minute_now = minutes_q;
    r.low_now    = low_q;
    return r;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ccds_out_t want;
    if (!rst_ni) begin
      hours_q      = '0;
      minutes_q    = '0;
      low_q        = '0;
      scan_pos_q   = '0;
      stopwatch_q  = 1'b0;
      readout_q.delete();
      fail_count_o = 0;
      open_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (readout_q.size() == 0) begin
          $display("%0t ns: result word with nothing expected, got %h", $time, out_data_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = readout_q.pop_front();
          check_field("hour_now", want.hour_now, out_data_i.hour_now);
          check_field("minute_now", want.minute_now, out_data_i.minute_now);
          check_field("low_now", want.low_now, out_data_i.low_now);
          check_field("segment_pattern", want.segment_pattern, out_data_i.segment_pattern);
          check_field("digit_select", want.digit_select, out_data_i.digit_select);
        end
      end
      if (cfg_valid_i && cfg_ready_i) stopwatch_q = cfg_data_i;
      if (in_valid_i && in_ready_i) readout_q.push_back(next_readout(in_data_i));
      open_count_o = readout_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ccds_pkg::*;

  // command code with no meaning for the block, and no field blanked
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] BLANK_NONE = 2'd0;

  localparam logic MODE_CLOCK     = 1'b0;
  localparam logic MODE_STOPWATCH = 1'b1;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned HOLD_CYCLES     = 300;  // long receiver hold-off
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;    // lets the pipeline settle after the last result

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  ccds_in_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_ready;
  logic      out_valid;
  logic      cfg_ready;
  ccds_out_t out_data;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request   = 1'b0;

  clock_counter_with_digit_scan dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  clock_counter_checker readout_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL clock_counter_with_digit_scan");
      $finish;
    end
  end

  // receiver: random stalls at the current rate, or one long hold-off on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        // counted here so the sender keeps pushing words into a full pipeline
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // builds one command word field by field
  function automatic ccds_in_t word(input logic [1:0] cmd, input logic [18:0] amount,
                                    input logic [4:0] hour, input logic [5:0] minute,
                                    input logic [6:0] low, input logic bl,
                                    input logic [1:0] field);
    ccds_in_t w;
    w.cmd         = cmd;
    w.add_amount  = amount;
    w.set_hour    = hour;
    w.set_minute  = minute;
    w.set_low     = low;
    w.blank       = bl;
    w.blank_field = field;
    return w;
  endfunction

  // random command word; unused fields carry random bits too
  function automatic ccds_in_t random_word();
    ccds_in_t    w;
    int unsigned pick;
    w.add_amount  = 19'($urandom);
    w.set_hour    = 5'($urandom_range(31));
    w.set_minute  = 6'($urandom_range(63));
    w.set_low     = 7'($urandom_range(127));
    w.blank       = 1'($urandom_range(1));
    w.blank_field = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.cmd = CMD_ADD;
      // mostly small steps, some minute and hour carries, a few huge jumps
      pick = $urandom_range(9);
      if (pick < 6)      w.add_amount = 19'($urandom_range(150));
      else if (pick < 8) w.add_amount = 19'($urandom_range(8000));
      else if (pick < 9) w.add_amount = 19'($urandom_range(524287));
    end else if (pick < 50) begin
      w.cmd = CMD_SET;
      // mostly legal times, sometimes out of range to hit the wrap
      if ($urandom_range(4) != 0) begin
        w.set_hour   = 5'($urandom_range(23));
        w.set_minute = 6'($urandom_range(59));
        w.set_low    = 7'($urandom_range(99));
      end
    end else if (pick < 90) begin
      w.cmd = CMD_SCAN;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  // offers one word, with an optional random gap first; valid stays high
  // after acceptance so the next word can follow without a bubble
  task automatic send_word(input ccds_in_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // drops valid, waits for every expected word, then lets the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    ccds_in_t    w;
    int unsigned counted;
    bit          held;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: clock mode, rollover of the whole day, out-of-range set
    write_mode(MODE_CLOCK);
    send_word(word(CMD_SET, 19'd0, 5'd23, 6'd59, 7'd59, 1'b0, BLANK_NONE));
    send_word(word(CMD_ADD, 19'd1, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));
    send_word(word(CMD_SET, 19'd0, 5'd31, 6'd63, 7'd127, 1'b0, BLANK_NONE));
    send_word(word(CMD_ADD, 19'd0, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));
    send_word(word(CMD_ADD, 19'h7ffff, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));
    // one full scan with every field blanked in turn; dashes stay lit
    for (int k = 0; k < 8; k++) begin
      send_word(word(CMD_SCAN, 19'd0, 5'd0, 6'd0, 7'd0, 1'b1,
                     k < 2 ? BLANK_LOW : (k < 5 ? BLANK_MINUTE : BLANK_HOUR)));
    end
    // unused command with every other bit set must change nothing
    send_word(word(CMD_UNUSED, 19'h7ffff, 5'd31, 6'd63, 7'd127, 1'b1, BLANK_HOUR));

    // stopwatch mode: hundredths carry and wrap of an oversized set
    wait_idle();
    write_mode(MODE_STOPWATCH);
    send_word(word(CMD_SET, 19'd0, 5'd12, 6'd34, 7'd99, 1'b0, BLANK_NONE));
    send_word(word(CMD_ADD, 19'd1, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));
    send_word(word(CMD_SET, 19'd0, 5'd31, 6'd63, 7'd127, 1'b0, BLANK_NONE));
    send_word(word(CMD_SET, 19'd0, 5'd23, 6'd59, 7'd95, 1'b0, BLANK_NONE));

    // back to clock mode with a low count above 59: shown as is, then normalized
    wait_idle();
    write_mode(MODE_CLOCK);
    send_word(word(CMD_SCAN, 19'd0, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));
    send_word(word(CMD_SCAN, 19'd0, 5'd0, 6'd0, 7'd0, 1'b1, BLANK_MINUTE));
    send_word(word(CMD_ADD, 19'd0, 5'd0, 6'd0, 7'd0, 1'b0, BLANK_NONE));

    // random phases, each with its own idle pattern and mode
    held = 1'b0;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_mode(p[0] ? MODE_CLOCK : MODE_STOPWATCH);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // halfway through the free-running phase, the receiver stops for a while
        if (p == 0 && !held && counted == ITEMS_PER_PHASE / 2) begin
          held         = 1'b1;
          hold_request = 1'b1;
        end
        w = random_word();
        send_word(w);
        if (w.cmd != CMD_UNUSED) counted++;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS clock_counter_with_digit_scan");
    end else begin
      $display("FAIL clock_counter_with_digit_scan");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ccds_pkg.sv
rtl/clock_counter_with_digit_scan.sv
sim/clock_counter_checker.sv
sim/testbench.sv
